// ===== hw/rtl/dltq_pkg.sv =====
// Shared types and constants of the delta list timer queue.
package dltq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ACC_W = 32 + CNT_W;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [1:0] ST_TICK_DONE = 2'd0;
  localparam logic [1:0] ST_ENQUEUED  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [31:0] cookie;
    logic [15:0] tag;
    logic [31:0] delta;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             fired;
    logic [15:0]      tag;
    logic [31:0]      cookie;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

// ===== hw/rtl/dltq_store.sv =====
// Timer entry memory: one write and one registered read per cycle.
module dltq_store (
  input  logic                     clk_i,
  input  dltq_pkg::mem_req_t       req_i,
  output dltq_pkg::entry_t         rdata_o
);
  import dltq_pkg::*;

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

// ===== hw/rtl/dltq_ctrl.sv =====
// Sequencer for enqueue walk and shift, tick countdown and head pop.
module dltq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic               opcode_i,
  input  logic [31:0]        delay_us_i,
  input  logic [15:0]        tag_i,
  input  logic [31:0]        cookie_i,
  input  logic [15:0]        tpm_i,
  output dltq_pkg::mem_req_t mem_req_o,
  input  dltq_pkg::entry_t   mem_rdata_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output dltq_pkg::res_t     res_o
);
  import dltq_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_MUL  = 12'b000000000010,
    S_CHK  = 12'b000000000100,
    S_WRD  = 12'b000000001000,
    S_WCMP = 12'b000000010000,
    S_SRD  = 12'b000000100000,
    S_SWR  = 12'b000001000000,
    S_FIX  = 12'b000010000000,
    S_NEW  = 12'b000100000000,
    S_POP2 = 12'b001000000000,
    S_POP3 = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [31:0] cd_q, cd_d;
  logic [31:0] hd_q, hd_d;
  logic [31:0] delay_q, delay_d;
  logic [15:0] tag_q, tag_d;
  logic [31:0] cookie_q, cookie_d;
  logic [47:0] ticks_q, ticks_d;
  logic [32:0] target_q, target_d;
  logic [ACC_W-1:0] acc_q, acc_d, last_q, last_d;
  logic [CNT_W-1:0] k_q, k_d, i_q, i_d, j_q, j_d;
  entry_t brk_q, brk_d;
  res_t res_q, res_d;

  logic [31:0] tk;
  logic [31:0] elapsed;
  logic [31:0] diff;
  logic [31:0] cdm;
  logic [ACC_W-1:0] acc_n;

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o = '{status: res_q.status, fired: res_q.fired, tag: res_q.tag,
                   cookie: res_q.cookie, count: n_q};
  assign tk = (ticks_q[31:0] == 32'd0) ? 32'd1 : ticks_q[31:0];
  assign elapsed = (hd_q > cd_q) ? (hd_q - cd_q) : 32'd0;
  assign diff = target_q[31:0] - last_q[31:0];
  assign cdm = cd_q - 32'd1;
  assign acc_n = acc_q + ACC_W'(mem_rdata_i.delta);

  always_comb begin
    state_d = state_q;
    n_d = n_q;
    head_d = head_q;
    cd_d = cd_q;
    hd_d = hd_q;
    delay_d = delay_q;
    tag_d = tag_q;
    cookie_d = cookie_q;
    ticks_d = ticks_q;
    target_d = target_q;
    acc_d = acc_q;
    last_d = last_q;
    k_d = k_q;
    i_d = i_q;
    j_d = j_q;
    brk_d = brk_q;
    res_d = res_q;
    mem_req_o = '0;
    mem_req_o.raddr = head_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          res_d = '0;
          res_d.status = ST_TICK_DONE;
          if (opcode_i == OP_ENQUEUE) begin
            delay_d = delay_us_i;
            tag_d = tag_i;
            cookie_d = cookie_i;
            state_d = S_MUL;
          end else if (cd_q == 32'd0) begin
            state_d = S_DONE;
          end else begin
            cd_d = cdm;
            if (cdm != 32'd0 || n_q == '0) begin
              state_d = S_DONE;
            end else begin
              mem_req_o.raddr = head_q;
              state_d = S_POP2;
            end
          end
        end
      end
      S_MUL: begin
        ticks_d = delay_q * tpm_i;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (ticks_q[47:32] != 16'd0) begin
          res_d.status = ST_TOO_LONG;
          state_d = S_DONE;
        end else if (n_q == CNT_W'(QUEUE_DEPTH)) begin
          res_d.status = ST_FULL;
          state_d = S_DONE;
        end else if (n_q == '0) begin
          mem_req_o.we = 1'b1;
          mem_req_o.waddr = head_q;
          mem_req_o.wdata = '{cookie: cookie_q, tag: tag_q, delta: tk};
          cd_d = tk;
          hd_d = tk;
          n_d = CNT_W'(1);
          res_d.status = ST_ENQUEUED;
          state_d = S_DONE;
        end else begin
          target_d = {1'b0, tk} + {1'b0, elapsed};
          k_d = '0;
          acc_d = '0;
          last_d = '0;
          state_d = S_WRD;
        end
      end
      S_WRD: begin
        mem_req_o.raddr = head_q + k_q[IDX_W-1:0];
        state_d = S_WCMP;
      end
      S_WCMP: begin
        acc_d = acc_n;
        if (acc_n > ACC_W'(target_q)) begin
          brk_d = mem_rdata_i;
          i_d = k_q;
          j_d = n_q;
          state_d = (n_q >= k_q + CNT_W'(2)) ? S_SRD : S_FIX;
        end else begin
          last_d = acc_n;
          k_d = k_q + CNT_W'(1);
          if (k_q + CNT_W'(1) == n_q) begin
            i_d = n_q;
            state_d = S_NEW;
          end else begin
            state_d = S_WRD;
          end
        end
      end
      S_SRD: begin
        mem_req_o.raddr = head_q + j_q[IDX_W-1:0] - IDX_W'(1);
        state_d = S_SWR;
      end
      S_SWR: begin
        mem_req_o.we = 1'b1;
        mem_req_o.waddr = head_q + j_q[IDX_W-1:0];
        mem_req_o.wdata = mem_rdata_i;
        j_d = j_q - CNT_W'(1);
        state_d = (j_q - CNT_W'(1) >= i_q + CNT_W'(2)) ? S_SRD : S_FIX;
      end
      S_FIX: begin
        mem_req_o.we = 1'b1;
        mem_req_o.waddr = head_q + i_q[IDX_W-1:0] + IDX_W'(1);
        mem_req_o.wdata = '{cookie: brk_q.cookie, tag: brk_q.tag,
                            delta: brk_q.delta - diff};
        state_d = S_NEW;
      end
      S_NEW: begin
        mem_req_o.we = 1'b1;
        mem_req_o.waddr = head_q + i_q[IDX_W-1:0];
        mem_req_o.wdata = '{cookie: cookie_q, tag: tag_q, delta: diff};
        if (i_q == '0) begin
          cd_d = tk;
          hd_d = diff;
        end
        n_d = n_q + CNT_W'(1);
        res_d.status = ST_ENQUEUED;
        state_d = S_DONE;
      end
      S_POP2: begin
        res_d.fired = 1'b1;
        res_d.tag = mem_rdata_i.tag;
        res_d.cookie = mem_rdata_i.cookie;
        head_d = head_q + IDX_W'(1);
        n_d = n_q - CNT_W'(1);
        mem_req_o.raddr = head_q + IDX_W'(1);
        state_d = (n_q == CNT_W'(1)) ? S_DONE : S_POP3;
      end
      S_POP3: begin
        hd_d = mem_rdata_i.delta;
        cd_d = (mem_rdata_i.delta == 32'd0) ? 32'd1 : mem_rdata_i.delta;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q <= '0;
      head_q <= '0;
      cd_q <= '0;
      hd_q <= '0;
    end else begin
      state_q <= state_d;
      n_q <= n_d;
      head_q <= head_d;
      cd_q <= cd_d;
      hd_q <= hd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delay_q <= delay_d;
    tag_q <= tag_d;
    cookie_q <= cookie_d;
    ticks_q <= ticks_d;
    target_q <= target_d;
    acc_q <= acc_d;
    last_q <= last_d;
    k_q <= k_d;
    i_q <= i_d;
    j_q <= j_d;
    brk_q <= brk_d;
    res_q <= res_d;
  end

endmodule

// ===== hw/rtl/delta_list_timer_queue_top.sv =====
// Top level of the delta list timer queue: ports, configuration and output register.
//
// One request enters on the s_axis side: tuser is the opcode (0 enqueue, 1 tick),
// tdata carries delay_us, callback_tag and cookie. Each request gives exactly one
// response on the m_axis side: tuser is the status, tdata carries fired, the
// expired tag and cookie, and the pending count.
// A tick counts a running countdown down and pops the head when it reaches zero. An
// enqueue multiplies the delay by ticks per microsecond and is rejected if too long
// or the queue is full; into an empty queue it is written at once, else the walk and
// shift sequencer walks the entries in the entry memory, moves the later ones up,
// adjusts the entry after the new one when there is one, and writes the new entry.
// A new request is taken once the previous one is finished, while its response
// still waits in the output register. When the receiver stalls, the response
// holds and the next finished response waits in the sequencer.
// Reset empties the queue, clears the countdown and sets ticks per microsecond
// to one. cfg_we_i writes ticks per microsecond; write it only while idle.
module delta_list_timer_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // delay_us[31:0], callback_tag[47:32], cookie[79:48]
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // fired[0], fired_tag[16:1], fired_cookie[48:17],
                                     // queue_count[53:49], zero fill
  output logic [1:0]  m_axis_tuser   // status
);
  import dltq_pkg::*;

  logic [15:0] tpm_q;
  mem_req_t mem_req;
  entry_t mem_rdata;
  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid_q;
  res_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q <= 16'd1;
    end else if (cfg_we_i) begin
      tpm_q <= cfg_wdata_i;
    end
  end

  dltq_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  dltq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .delay_us_i  (s_axis_tdata[31:0]),
    .tag_i       (s_axis_tdata[47:32]),
    .cookie_i    (s_axis_tdata[79:48]),
    .tpm_i       (tpm_q),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser = out_q.status;
  assign m_axis_tdata = {2'b00, out_q.count, out_q.cookie, out_q.tag, out_q.fired};

endmodule

// ===== sim/dltq_checker.sv =====
// Checker for the delta list timer queue: watches both streams, predicts and compares.
module dltq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count,
  output int          pending_resp,
  output int          fired_seen
);
  import dltq_pkg::*;

  logic [31:0] delta_q [QUEUE_DEPTH];
  logic [15:0] tag_q [QUEUE_DEPTH];
  logic [31:0] cookie_q [QUEUE_DEPTH];
  int unsigned timer_count;
  logic [31:0] countdown;
  logic [15:0] ticks_per_us;
  res_t resp_fifo[$];

  function automatic res_t predict_request(logic op, logic [31:0] delay, logic [15:0] tag,
                                           logic [31:0] ck);
    res_t r;
    logic [63:0] ticks, target, acc, last;
    logic [31:0] elapsed, diff;
    int unsigned i;
    r = '0;
    if (op == OP_ENQUEUE) begin
      ticks = {32'd0, delay} * {48'd0, ticks_per_us};
      if (ticks > 64'hFFFF_FFFF) r.status = ST_TOO_LONG;
      else begin
        if (ticks == 0) ticks = 1;
        if (timer_count >= QUEUE_DEPTH) r.status = ST_FULL;
        else begin
          r.status = ST_ENQUEUED;
          if (timer_count == 0) begin
            countdown = ticks[31:0];
            delta_q[0] = ticks[31:0];
            tag_q[0] = tag;
            cookie_q[0] = ck;
            timer_count = 1;
          end else begin
            elapsed = (delta_q[0] > countdown) ? delta_q[0] - countdown : 32'd0;
            target = ticks + {32'd0, elapsed};
            acc = 0;
            last = 0;
            for (i = 0; i < timer_count; i++) begin
              acc += {32'd0, delta_q[i]};
              if (acc > target) break;
              last = acc;
            end
            diff = 32'(target - last);
            if (i < timer_count) begin
              for (int j = timer_count; j > i; j--) begin
                delta_q[j] = delta_q[j-1];
                tag_q[j] = tag_q[j-1];
                cookie_q[j] = cookie_q[j-1];
              end
              delta_q[i+1] = delta_q[i+1] - diff;
            end
            if (i == 0) countdown = ticks[31:0];
            delta_q[i] = diff;
            tag_q[i] = tag;
            cookie_q[i] = ck;
            timer_count++;
          end
        end
      end
    end else if (countdown != 0) begin
      countdown--;
      if (countdown == 0 && timer_count != 0) begin
        r.fired = 1'b1;
        r.tag = tag_q[0];
        r.cookie = cookie_q[0];
        timer_count--;
        for (int k = 0; k < timer_count; k++) begin
          delta_q[k] = delta_q[k+1];
          tag_q[k] = tag_q[k+1];
          cookie_q[k] = cookie_q[k+1];
        end
        if (timer_count > 0) countdown = (delta_q[0] == 0) ? 32'd1 : delta_q[0];
      end
    end
    r.count = CNT_W'(timer_count);
    return r;
  endfunction

  assign pending_resp = resp_fifo.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want, got;
    if (!rst_ni) begin
      timer_count = 0;
      countdown = '0;
      ticks_per_us = 16'd1;
      resp_fifo.delete();
      fail_count = 0;
      fired_seen = 0;
    end else begin
      if (cfg_we_i) ticks_per_us = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        resp_fifo.push_back(predict_request(s_axis_tuser, s_axis_tdata[31:0],
                                            s_axis_tdata[47:32], s_axis_tdata[79:48]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.fired = m_axis_tdata[0];
        got.tag = m_axis_tdata[16:1];
        got.cookie = m_axis_tdata[48:17];
        got.count = m_axis_tdata[53:49];
        if (resp_fifo.size() == 0) begin
          $error("unexpected response %p", got);
          fail_count++;
        end else begin
          want = resp_fifo.pop_front();
          if (got.fired) fired_seen++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.fired !== want.fired) begin
            $error("fired: expected %0d, got %0d", want.fired, got.fired);
            fail_count++;
          end
          if (got.tag !== want.tag) begin
            $error("fired_tag: expected %h, got %h", want.tag, got.tag);
            fail_count++;
          end
          if (got.cookie !== want.cookie) begin
            $error("fired_cookie: expected %h, got %h", want.cookie, got.cookie);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $error("queue_count: expected %0d, got %0d", want.count, got.count);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== sim/tb_delta_list_timer_queue_top.sv =====
// Testbench top for the delta list timer queue: clock, reset, stimulus and verdict.
module tb_delta_list_timer_queue_top;
  import dltq_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count, pending_resp, fired_seen;
  int          quiet_cycles = 0;
  int          requests_sent = 0;
  bit          rx_random = 1'b1;

  always #6 clk_i = ~clk_i;

  delta_list_timer_queue_top dut (.*);

  dltq_checker u_checker (.*);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_resp == 0 && !s_axis_tvalid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, with quiet stretches
  always @(posedge clk_i) begin
    int gap;
    if (rst_ni) begin
      if (m_axis_tready && m_axis_tvalid) begin
        gap = rx_random ? $urandom_range(0, 14) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end else
        m_axis_tready <= 1'b1;
    end
  end

  task automatic send_request(logic op, logic [31:0] delay, logic [15:0] tag,
                              logic [31:0] ck, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {ck, tag, delay};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  task automatic write_rate(logic [15:0] rate);
    s_axis_tvalid <= 1'b0;
    wait (pending_resp == 0);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= rate;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic tick_burst(int n);
    for (int k = 0; k < n; k++)
      send_request(OP_TICK, $urandom, $urandom, $urandom, $urandom_range(0, 2) != 0);
  endtask

  task automatic random_phase(int n, int max_delay);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 2) == 0)
        send_request(OP_ENQUEUE, $urandom_range(0, max_delay), $urandom, $urandom,
                     $urandom_range(0, 1));
      else
        send_request(OP_TICK, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick, zero and maximal delays, ties, head insertion, full queue
    send_request(OP_TICK, '1, '1, '1, 1'b0);
    send_request(OP_ENQUEUE, 32'd0, 16'h0000, 32'h0, 1'b0);
    send_request(OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_ENQUEUE, 32'd5, 16'h1234, 32'hA5A5_5A5A, 1'b0);
    send_request(OP_ENQUEUE, 32'd5, 16'h4321, 32'h5A5A_A5A5, 1'b0);
    send_request(OP_TICK, '0, '0, '0, 1'b0);
    send_request(OP_TICK, '0, '0, '0, 1'b0);
    send_request(OP_ENQUEUE, 32'd2, 16'h00FF, 32'h0000_FFFF, 1'b0);
    for (int k = 0; k < 12; k++)
      send_request(OP_ENQUEUE, $urandom_range(1, 40), $urandom, $urandom, 1'b1);
    send_request(OP_ENQUEUE, 32'd3, 16'hBEEF, 32'hDEAD_BEEF, 1'b0);
    tick_burst(50);

    write_rate(16'hFFFF);
    send_request(OP_ENQUEUE, 32'h0001_0001, 16'h0001, 32'h1, 1'b0);
    send_request(OP_ENQUEUE, 32'h0001_0002, 16'h0002, 32'h2, 1'b0);
    send_request(OP_ENQUEUE, 32'd0, 16'h0003, 32'h3, 1'b0);
    tick_burst(3);

    write_rate(16'd0);
    random_phase(60, 100);
    tick_burst(30);

    rx_random = 1'b0;
    write_rate(16'd1);
    random_phase(200, 30);
    rx_random = 1'b1;

    write_rate(16'd3);
    random_phase(200, 12);

    write_rate(16'd1);
    random_phase(100, 8);
    for (int r = 0; r < 6 && u_checker.timer_count > 0; r++) tick_burst(5);
    s_axis_tvalid <= 1'b0;

    wait (pending_resp == 0);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d requests over rates 1, 3, 0 and 65535; %0d timers fired.",
             requests_sent, fired_seen);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
